>>> hw/rtl/palfm_pkg.sv
// Shared types, codes and helpers for the prefix access list block.
`timescale 1ns / 1ps
package palfm_pkg;

  localparam int RULE_SLOTS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int PREFIX_W    = 32;
  localparam int LEN_W       = 6;
  localparam int HIT_INDEX_W = 4;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_APPLY  = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [PREFIX_W-1:0] prefix;
    logic [LEN_W-1:0]    prefix_len;
    logic                action;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   verdict;
    logic                   hit;
    logic [HIT_INDEX_W-1:0] hit_index;
  } rsp_t;

  typedef struct packed {
    logic [PREFIX_W-1:0] prefix;
    logic [LEN_W-1:0]    prefix_len;
    logic                action;
  } rule_t;

  typedef enum logic [3:0] {
    CMD_APPEND = 4'b0001,
    CMD_DELETE = 4'b0010,
    CMD_APPLY  = 4'b0100,
    CMD_IGNORE = 4'b1000
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    rule_t     rule;
  } cmd_t;

  function automatic cmd_kind_t classify(input logic [1:0] op);
    cmd_kind_t k;
    case (op)
      OP_APPEND: k = CMD_APPEND;
      OP_DELETE: k = CMD_DELETE;
      OP_APPLY:  k = CMD_APPLY;
      default:   k = CMD_IGNORE;
    endcase
    return k;
  endfunction

  // Network mask for a rule length; lengths past 32 compare all bits.
  function automatic logic [PREFIX_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [PREFIX_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= LEN_W'(PREFIX_W)) begin
      m = '1;
    end else begin
      m = ~({PREFIX_W{1'b1}} >> len);
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/prefix_access_list_first_match_top.sv
// Top level of the prefix access list: front stage, command queue and rule engine.
// A request passes the front register and queue, is popped in S_IDLE and answered from S_EMIT,
// which rsp_stall can hold. An apply reads and compares (S_SCAN_RD, S_SCAN_CMP) each rule
// up to and including the first hit; a delete scans to the match, then moves later rules up
// (S_SHIFT_RD, S_SHIFT_WR). One request runs in the engine at a time; the front register and
// the 2-entry queue hold up to 3 waiting requests before req_stall rises.
// Reset (rst, synchronous) empties the list and queue; rule memory contents stay undefined.
`timescale 1ns / 1ps
module prefix_access_list_first_match_top #(
  parameter int RULE_SLOTS = palfm_pkg::RULE_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  palfm_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output palfm_pkg::rsp_t rsp
);

  // Front to queue: one classified command per push.
  logic            push;
  palfm_pkg::cmd_t push_cmd;
  logic            queue_full;

  // Queue to engine: head of queue, popped when the engine is idle.
  logic            head_valid;
  palfm_pkg::cmd_t head;
  logic            pop;

  // Register the request and tag it as append, delete, apply or ignore.
  palfm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  // Hold commands while the engine is busy scanning or shifting.
  palfm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Carry out each command against the ordered rule list and register the response.
  palfm_back #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head),
    .cmd_pop   (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> hw/rtl/palfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module palfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/palfm_front.sv
// Front stage: takes requests, classifies the opcode and hands commands to the queue.
`timescale 1ns / 1ps
module palfm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  palfm_pkg::req_t   req,
  output logic              push,
  output palfm_pkg::cmd_t   push_cmd,
  input  logic              queue_full
);

  logic            hold;
  logic            hold_next;
  logic            accept;
  palfm_pkg::cmd_t cmd;

  assign req_stall = hold && queue_full;
  assign accept    = req_valid && !req_stall;
  assign push      = hold && !queue_full;
  assign push_cmd  = cmd;

  always_comb begin
    hold_next = hold;
    if (accept) begin
      hold_next = 1'b1;
    end else if (push) begin
      hold_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else begin
      hold <= hold_next;
    end
    if (accept) begin
      cmd.kind            <= palfm_pkg::classify(req.op);
      cmd.rule.prefix     <= req.prefix;
      cmd.rule.prefix_len <= req.prefix_len;
      cmd.rule.action     <= req.action;
    end
  end

endmodule

>>> hw/rtl/palfm_queue.sv
// Short command queue between the front stage and the rule engine.
`timescale 1ns / 1ps
module palfm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  palfm_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output palfm_pkg::cmd_t head
);

  localparam int PTR_W  = (palfm_pkg::QUEUE_DEPTH > 1) ? $clog2(palfm_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(palfm_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(palfm_pkg::QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(palfm_pkg::QUEUE_DEPTH);

  palfm_pkg::cmd_t   slots [palfm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full       = (fill == FULL_FILL);
  assign head_valid = (fill != '0);
  assign head       = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/palfm_back.sv
// Rule engine: owns the rule memory and the count, runs append, delete and apply.
`timescale 1ns / 1ps
module palfm_back #(
  parameter int RULE_SLOTS = palfm_pkg::RULE_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  palfm_pkg::cmd_t cmd,
  output logic            cmd_pop,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output palfm_pkg::rsp_t rsp
);

  localparam int IDX_W  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
  localparam int RULE_W = $bits(palfm_pkg::rule_t);
  localparam logic [CNT_W:0] SLOTS_EXT = (CNT_W + 1)'(RULE_SLOTS);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN_RD  = 6'b000010,
    S_SCAN_CMP = 6'b000100,
    S_SHIFT_RD = 6'b001000,
    S_SHIFT_WR = 6'b010000,
    S_EMIT     = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  palfm_pkg::cmd_t   cur;
  palfm_pkg::rsp_t   res;
  palfm_pkg::rsp_t   res_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [RULE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [RULE_W-1:0] ram_rdata;

  palfm_pkg::rule_t  rd_rule;
  logic [CNT_W:0]    idx_inc;
  logic [CNT_W:0]    count_ext;
  logic              more;
  logic              more_shift;
  logic              apply_match;
  logic              del_match;
  logic              out_free;

  palfm_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULE_SLOTS)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_rule    = palfm_pkg::rule_t'(ram_rdata);
  assign idx_inc    = (CNT_W + 1)'(idx) + 1'b1;
  assign count_ext  = {1'b0, count};
  assign more       = idx_inc < count_ext;
  assign more_shift = (idx_inc + 1'b1) < count_ext;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign cmd_pop    = (state == S_IDLE) && cmd_valid;

  assign apply_match = (rd_rule.prefix_len <= cur.rule.prefix_len) &&
                       (((rd_rule.prefix ^ cur.rule.prefix) &
                         palfm_pkg::len_mask(rd_rule.prefix_len)) == '0);
  assign del_match   = (rd_rule == cur.rule);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    res_next   = res;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = cur.rule;
    ram_re     = 1'b0;
    ram_raddr  = idx;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          res_next = '0;
          idx_next = '0;
          case (cmd.kind)
            palfm_pkg::CMD_APPEND: begin
              if (count_ext >= SLOTS_EXT) begin
                res_next.status = palfm_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count[IDX_W-1:0];
                ram_wdata  = cmd.rule;
                count_next = count + 1'b1;
              end
              state_next = S_EMIT;
            end
            palfm_pkg::CMD_DELETE: begin
              if (count == '0) begin
                res_next.status = palfm_pkg::ST_NOT_FOUND;
                state_next      = S_EMIT;
              end else begin
                state_next = S_SCAN_RD;
              end
            end
            palfm_pkg::CMD_APPLY: begin
              state_next = (count == '0) ? S_EMIT : S_SCAN_RD;
            end
            default: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = idx;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        case (cur.kind)
          palfm_pkg::CMD_APPLY: begin
            if (apply_match) begin
              res_next.verdict   = rd_rule.action;
              res_next.hit       = 1'b1;
              res_next.hit_index = palfm_pkg::HIT_INDEX_W'(idx);
              state_next         = S_EMIT;
            end else if (more) begin
              idx_next   = idx + 1'b1;
              state_next = S_SCAN_RD;
            end else begin
              state_next = S_EMIT;
            end
          end
          palfm_pkg::CMD_DELETE: begin
            if (del_match) begin
              if (more) begin
                state_next = S_SHIFT_RD;
              end else begin
                count_next      = count - 1'b1;
                res_next.status = palfm_pkg::ST_DONE;
                state_next      = S_EMIT;
              end
            end else if (more) begin
              idx_next   = idx + 1'b1;
              state_next = S_SCAN_RD;
            end else begin
              res_next.status = palfm_pkg::ST_NOT_FOUND;
              state_next      = S_EMIT;
            end
          end
          default: begin
            state_next = S_EMIT;
          end
        endcase
      end
      S_SHIFT_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = idx_inc[IDX_W-1:0];
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        idx_next  = idx + 1'b1;
        if (more_shift) begin
          state_next = S_SHIFT_RD;
        end else begin
          count_next      = count - 1'b1;
          res_next.status = palfm_pkg::ST_DONE;
          state_next      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    idx <= idx_next;
    res <= res_next;
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state == S_EMIT && out_free) begin
      rsp <= res;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count_ext <= SLOTS_EXT)
    else $error("rule count above slot count");

  a_full_append_keeps_count : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid && cmd.kind == palfm_pkg::CMD_APPEND &&
     count_ext == SLOTS_EXT) |=> (count == $past(count)))
    else $error("append on full list changed the count");

  a_miss_fields_clear : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.hit) |-> (!rsp.verdict && rsp.hit_index == '0))
    else $error("miss response carries verdict or index");

  a_status_no_hit : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != palfm_pkg::ST_DONE) |-> !rsp.hit)
    else $error("error status together with a hit");

  a_shift_order : assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_WR) |-> ($past(state) == S_SHIFT_RD))
    else $error("shift write without a preceding read");

endmodule
